// ----- design/mickey_pkg.sv -----
package mickey_pkg;

  localparam int NBITS = 100;
  localparam int MAX_BURST = 64;
  localparam int BYTE_COUNT_W = 7;
  localparam int CNT_W = 7;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int SEED_W = 80;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_UPPER = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOWER = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IV_UPPER = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_IV_LOWER = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_IV_LENGTH = 3'd4;

  // request types
  localparam logic REQ_SETUP = 1'b0;
  localparam logic REQ_GENERATE = 1'b1;

  localparam logic [3:0] IV_BYTES_MAX = 4'd10;
  localparam logic [CNT_W-1:0] KEY_LAST = CNT_W'(SEED_W - 1);
  localparam logic [CNT_W-1:0] PRE_LAST = CNT_W'(NBITS - 1);
  localparam logic [BYTE_COUNT_W-1:0] BURST_MAX = BYTE_COUNT_W'(MAX_BURST);

  // control taps between the two registers
  localparam int S_TAP_CR = 34;
  localparam int R_TAP_CR = 67;
  localparam int S_TAP_CS = 67;
  localparam int R_TAP_CS = 33;
  localparam int S_TAP_MIX = 50;
  localparam int LAST_BIT = 99;

  // element i of each table is index i
  localparam logic [0:NBITS-1] TAP_R =
    100'b110111100100110010011110010010_000000011001100110001010101010_110111110001100000011110000111_1110111100;
  localparam logic [0:NBITS-2] CMP_A =
    99'b0000110001011110100101010_1010110100100000001010101_0000101001111001010111111_111010111111010100000011;
  localparam logic [0:NBITS-2] CMP_B =
    99'b0101100101111001010001101_0111011110001101011100001_0001011100011111101011101_111000100001110001001100;
  localparam logic [0:NBITS-1] FBK_A =
    100'b1111010111111110010111111_1111001100000011100100101_0100101111010101000000000_1101000110111001110011000;
  localparam logic [0:NBITS-1] FBK_B =
    100'b1110111000011101001100010_0110010110001100000110110_0010001001001011010100101_0001111011111000000100001;

  typedef struct packed {
    logic clear;
    logic load_iv;
    logic load_key;
    logic step;
    logic mix;
    logic use_din;
    logic capture;
    logic emit;
    logic emit_ack;
    logic emit_last;
  } mickey_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] iv_bits;
  } mickey_stat_t;

endpackage

// ----- design/mickey_if.sv -----
interface mickey_req_if import mickey_pkg::*; ();
  logic valid;
  logic ready;
  logic req_type;
  logic [BYTE_COUNT_W-1:0] byte_count;

  modport source (output valid, req_type, byte_count, input ready);
  modport sink (input valid, req_type, byte_count, output ready);
endinterface

interface mickey_res_if ();
  logic valid;
  logic ready;
  logic [7:0] keystream_byte;
  logic last_of_run;
  logic setup_ack;

  modport source (output valid, keystream_byte, last_of_run, setup_ack, input ready);
  modport sink (input valid, keystream_byte, last_of_run, setup_ack, output ready);
endinterface

// ----- design/mickey_stream_cipher_keystream_top.sv -----
// MICKEY 2.0 keystream generator. Load key and IV over the configuration port while the
// block is idle, then send a setup request (req_type 0): it clears both 100-bit registers,
// clocks in the first iv_length_bytes IV bytes (capped at 10) and the 80-bit key MSB first,
// runs 100 preclocks and returns one acknowledge item with setup_ack set. A generate
// request (req_type 1) returns byte_count keystream bytes (capped at 64, none for zero),
// first bit in bit 7, last_of_run on the final one. The datapath clocks the register
// pair once per cycle unless stalled; an output register holds a finished item while
// the next byte is built, and back-pressure stalls the registers only at a byte boundary.
// One request is handled at a time; the next is taken once the current one has put out
// its last item.
module mickey_stream_cipher_keystream_top import mickey_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  mickey_req_if.sink             req,
  mickey_res_if.source           res,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  mickey_cmd_t cmd;
  mickey_stat_t stat;

  mickey_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .req_type   (req.req_type),
    .byte_count (req.byte_count),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  mickey_core u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .stat           (stat),
    .keystream_byte (res.keystream_byte),
    .last_of_run    (res.last_of_run),
    .setup_ack      (res.setup_ack)
  );

endmodule

// ----- design/mickey_ctrl.sv -----
module mickey_ctrl import mickey_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    req_type,
  input  logic [BYTE_COUNT_W-1:0] byte_count,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  mickey_stat_t            stat,
  output mickey_cmd_t             cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_IV   = 3'd1;
  localparam logic [2:0] ST_KEY  = 3'd2;
  localparam logic [2:0] ST_PRE  = 3'd3;
  localparam logic [2:0] ST_ACK  = 3'd4;
  localparam logic [2:0] ST_GEN  = 3'd5;

  logic [2:0] state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [BYTE_COUNT_W-1:0] bytes_left, bytes_left_next;
  logic [2:0] bit_idx, bit_idx_next;
  logic out_valid_next;
  logic slot_free;
  logic [BYTE_COUNT_W-1:0] burst;

  assign slot_free = !out_valid || out_ready;
  assign burst = (byte_count > BURST_MAX) ? BURST_MAX : byte_count;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    cnt_next = cnt;
    bytes_left_next = bytes_left;
    bit_idx_next = bit_idx;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_SETUP) begin
            cmd.clear = 1'b1;
            cnt_next = '0;
            if (stat.iv_bits != '0) begin
              cmd.load_iv = 1'b1;
              state_next = ST_IV;
            end else begin
              cmd.load_key = 1'b1;
              state_next = ST_KEY;
            end
          end else if (burst != '0) begin
            bytes_left_next = burst;
            bit_idx_next = '0;
            state_next = ST_GEN;
          end
        end
      end
      ST_IV: begin
        cmd.step = 1'b1;
        cmd.mix = 1'b1;
        cmd.use_din = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == stat.iv_bits - 1'b1) begin
          cmd.load_key = 1'b1;
          cnt_next = '0;
          state_next = ST_KEY;
        end
      end
      ST_KEY: begin
        cmd.step = 1'b1;
        cmd.mix = 1'b1;
        cmd.use_din = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == KEY_LAST) begin
          cnt_next = '0;
          state_next = ST_PRE;
        end
      end
      ST_PRE: begin
        cmd.step = 1'b1;
        cmd.mix = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == PRE_LAST) begin
          state_next = ST_ACK;
        end
      end
      ST_ACK: begin
        if (slot_free) begin
          cmd.emit = 1'b1;
          cmd.emit_ack = 1'b1;
          cmd.emit_last = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_GEN: begin
        if (bit_idx != 3'd7) begin
          cmd.step = 1'b1;
          cmd.capture = 1'b1;
          bit_idx_next = bit_idx + 1'b1;
        end else if (slot_free) begin
          // eighth bit goes straight into the output register
          cmd.step = 1'b1;
          cmd.emit = 1'b1;
          cmd.emit_last = (bytes_left == BYTE_COUNT_W'(1));
          bit_idx_next = '0;
          bytes_left_next = bytes_left - 1'b1;
          if (bytes_left == BYTE_COUNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      bytes_left <= '0;
      bit_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      bytes_left <= bytes_left_next;
      bit_idx <= bit_idx_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- design/mickey_core.sv -----
module mickey_core import mickey_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  mickey_cmd_t            cmd,
  output mickey_stat_t           stat,
  output logic [7:0]             keystream_byte,
  output logic                   last_of_run,
  output logic                   setup_ack
);

  logic [15:0] key_upper, iv_upper;
  logic [63:0] key_lower, iv_lower;
  logic [3:0] iv_length_bytes;
  logic [3:0] iv_bytes;

  logic [NBITS-1:0] reg_r, reg_s, r_next, s_next;
  logic [SEED_W-1:0] seed;
  logic [6:0] acc;
  logic din, dr, cr, cs, fb_r, fb_s, ks_bit;

  assign iv_bytes = (iv_length_bytes > IV_BYTES_MAX) ? IV_BYTES_MAX : iv_length_bytes;
  assign stat.iv_bits = {iv_bytes, 3'b000};

  assign ks_bit = reg_r[0] ^ reg_s[0];
  assign din = cmd.use_din & seed[SEED_W-1];
  assign cr = reg_s[S_TAP_CR] ^ reg_r[R_TAP_CR];
  assign cs = reg_s[S_TAP_CS] ^ reg_r[R_TAP_CS];
  assign dr = cmd.mix ? (din ^ reg_s[S_TAP_MIX]) : din;
  assign fb_r = reg_r[LAST_BIT] ^ dr;
  assign fb_s = reg_s[LAST_BIT] ^ din;

  // one combined clock of both registers
  always_comb begin
    for (int i = 0; i < NBITS; i++) begin
      r_next[i] = ((i == 0) ? 1'b0 : reg_r[(i == 0) ? 0 : i - 1]) ^ (TAP_R[i] & fb_r)
                  ^ (cr & reg_r[i]);
    end
    s_next[0] = 1'b0;
    for (int i = 1; i < NBITS - 1; i++) begin
      s_next[i] = reg_s[i-1] ^ ((reg_s[i] ^ CMP_A[i]) & (reg_s[i+1] ^ CMP_B[i]));
    end
    s_next[NBITS-1] = reg_s[NBITS-2];
    for (int i = 0; i < NBITS; i++) begin
      s_next[i] = s_next[i] ^ ((cs ? FBK_B[i] : FBK_A[i]) & fb_s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= '0;
      key_lower <= '0;
      iv_upper <= '0;
      iv_lower <= '0;
      iv_length_bytes <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_UPPER: key_upper <= cfg_data[15:0];
        CFG_KEY_LOWER: key_lower <= cfg_data;
        CFG_IV_UPPER:  iv_upper <= cfg_data[15:0];
        CFG_IV_LOWER:  iv_lower <= cfg_data;
        CFG_IV_LENGTH: iv_length_bytes <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_r <= '0;
      reg_s <= '0;
    end else if (cmd.clear) begin
      reg_r <= '0;
      reg_s <= '0;
    end else if (cmd.step) begin
      reg_r <= r_next;
      reg_s <= s_next;
    end
  end

  // seed bits leave MSB first; a load replaces the shift on the phase change
  always_ff @(posedge clk) begin
    if (cmd.load_iv) begin
      seed <= {iv_upper, iv_lower};
    end else if (cmd.load_key) begin
      seed <= {key_upper, key_lower};
    end else if (cmd.step && cmd.use_din) begin
      seed <= {seed[SEED_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc <= {acc[5:0], ks_bit};
    end
    if (cmd.emit) begin
      keystream_byte <= cmd.emit_ack ? 8'h00 : {acc, ks_bit};
      last_of_run <= cmd.emit_last;
      setup_ack <= cmd.emit_ack;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import mickey_pkg::*;

  localparam int STAGES = 100;
  localparam int IV_BYTES_CAP = 10;
  localparam int BURST_CAP = 64;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int REPORT_LIMIT = 10;

  // register taps that steer the clocking of each register
  localparam int S_CTL_R = 34;
  localparam int R_CTL_R = 67;
  localparam int S_CTL_S = 67;
  localparam int R_CTL_S = 33;
  localparam int S_MIX = 50;

  // element i is stage i
  localparam logic [0:STAGES-1] R_TAPS =
    100'b110111100100110010011110010010_000000011001100110001010101010_110111110001100000011110000111_1110111100;
  localparam logic [0:STAGES-2] S_COMP0 =
    99'b0000110001011110100101010_1010110100100000001010101_0000101001111001010111111_111010111111010100000011;
  localparam logic [0:STAGES-2] S_COMP1 =
    99'b0101100101111001010001101_0111011110001101011100001_0001011100011111101011101_111000100001110001001100;
  localparam logic [0:STAGES-1] S_FB0 =
    100'b1111010111111110010111111_1111001100000011100100101_0100101111010101000000000_1101000110111001110011000;
  localparam logic [0:STAGES-1] S_FB1 =
    100'b1110111000011101001100010_0110010110001100000110110_0010001001001011010100101_0001111011111000000100001;

  typedef struct packed {
    logic [7:0] ks_byte;
    logic       last_run;
    logic       ack;
  } ks_item_t;

  class keystream_checker;
    logic [STAGES-1:0] reg_lin;
    logic [STAGES-1:0] reg_nl;
    logic [15:0] key_hi;
    logic [63:0] key_lo;
    logic [15:0] iv_hi;
    logic [63:0] iv_lo;
    logic [3:0]  iv_len;
    ks_item_t pending_items[$];
    int n_setup, n_generate, n_checked, n_bad, n_unexpected;

    function new();
      reg_lin = '0;
      reg_nl = '0;
      key_hi = '0;
      key_lo = '0;
      iv_hi = '0;
      iv_lo = '0;
      iv_len = '0;
      n_setup = 0;
      n_generate = 0;
      n_checked = 0;
      n_bad = 0;
      n_unexpected = 0;
    endfunction

    function void set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
      case (idx)
        CFG_KEY_UPPER: key_hi = data[15:0];
        CFG_KEY_LOWER: key_lo = data;
        CFG_IV_UPPER:  iv_hi = data[15:0];
        CFG_IV_LOWER:  iv_lo = data;
        CFG_IV_LENGTH: iv_len = data[3:0];
        default: ;
      endcase
    endfunction

    // one combined clock of both registers
    function void clock_pair(input logic mix, input logic din);
      logic [STAGES-1:0] r, s, nr, ns;
      logic ctl_r, ctl_s, fb_r, fb_s;
      int i;
      r = reg_lin;
      s = reg_nl;
      ctl_r = s[S_CTL_R] ^ r[R_CTL_R];
      ctl_s = s[S_CTL_S] ^ r[R_CTL_S];
      fb_r = r[STAGES-1] ^ (mix ? (din ^ s[S_MIX]) : din);
      fb_s = s[STAGES-1] ^ din;
      nr = {r[STAGES-2:0], 1'b0};
      for (i = 0; i < STAGES; i++) begin
        if (R_TAPS[i]) nr[i] = nr[i] ^ fb_r;
        if (ctl_r) nr[i] = nr[i] ^ r[i];
      end
      ns[0] = 1'b0;
      for (i = 1; i <= STAGES - 2; i++)
        ns[i] = s[i-1] ^ ((s[i] ^ S_COMP0[i]) & (s[i+1] ^ S_COMP1[i]));
      ns[STAGES-1] = s[STAGES-2];
      for (i = 0; i < STAGES; i++)
        ns[i] = ns[i] ^ ((ctl_s ? S_FB1[i] : S_FB0[i]) & fb_s);
      reg_lin = nr;
      reg_nl = ns;
    endfunction

    function void note_request(input logic rt, input logic [BYTE_COUNT_W-1:0] cnt);
      logic [79:0] iv_seed, key_seed;
      logic [7:0] acc;
      ks_item_t it;
      int n_iv, n_bytes, b, j, k;
      if (rt == REQ_SETUP) begin
        n_setup++;
        n_iv = (iv_len > IV_BYTES_CAP) ? IV_BYTES_CAP : iv_len;
        iv_seed = {iv_hi, iv_lo};
        key_seed = {key_hi, key_lo};
        reg_lin = '0;
        reg_nl = '0;
        for (k = 0; k < n_iv * 8; k++) clock_pair(1'b1, iv_seed[79-k]);
        for (k = 0; k < 80; k++) clock_pair(1'b1, key_seed[79-k]);
        for (k = 0; k < STAGES; k++) clock_pair(1'b1, 1'b0);
        it.ks_byte = '0;
        it.last_run = 1'b1;
        it.ack = 1'b1;
        pending_items.push_back(it);
      end else begin
        n_generate++;
        n_bytes = (cnt > BURST_CAP) ? BURST_CAP : cnt;
        for (b = 0; b < n_bytes; b++) begin
          acc = '0;
          for (j = 0; j < 8; j++) begin
            acc = {acc[6:0], reg_lin[0] ^ reg_nl[0]};
            clock_pair(1'b0, 1'b0);
          end
          it.ks_byte = acc;
          it.last_run = (b == n_bytes - 1);
          it.ack = 1'b0;
          pending_items.push_back(it);
        end
      end
    endfunction

    function void check_item(input logic [7:0] kb, input logic lr, input logic sa);
      ks_item_t want;
      n_checked++;
      if (pending_items.size() == 0) begin
        n_unexpected++;
        if (n_bad + n_unexpected <= REPORT_LIMIT)
          $display("unexpected result: byte %02h last %b ack %b", kb, lr, sa);
        return;
      end
      want = pending_items.pop_front();
      if (want.ks_byte !== kb || want.last_run !== lr || want.ack !== sa) begin
        n_bad++;
        if (n_bad + n_unexpected <= REPORT_LIMIT)
          $display("result %0d mismatch: expected byte %02h last %b ack %b, got byte %02h last %b ack %b",
                   n_checked, want.ks_byte, want.last_run, want.ack, kb, lr, sa);
      end
    endfunction

    function int pending();
      return pending_items.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mickey_req_if req_ch ();
  mickey_res_if res_ch ();

  keystream_checker sb;
  int stall_pct = 0;
  int ready_hold = 0;
  int cycle_count = 0;
  int n_configs = 0;
  int stall_plan[6] = '{0, 25, 60, 10, 40, 0};
  int gap_plan[6] = '{0, 4, 8, 2, 6, 3};

  mickey_stream_cipher_keystream_top i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", CYCLE_LIMIT, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      sb.note_request(req_ch.req_type, req_ch.byte_count);
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_item(res_ch.keystream_byte, res_ch.last_of_run, res_ch.setup_ack);
  end

  // receiver: runs of ready and stall whose mix follows stall_pct
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (ready_hold > 0) begin
        ready_hold--;
      end else if (stall_pct == 0 || $urandom_range(99) >= stall_pct) begin
        res_ch.ready <= 1'b1;
        ready_hold = $urandom_range(0, 6);
      end else begin
        res_ch.ready <= 1'b0;
        ready_hold = $urandom_range(0, 4);
      end
    end
  end

  // called just after the rising clock; returns in the step where the request is taken
  task automatic send_request(input logic rt, input logic [BYTE_COUNT_W-1:0] cnt);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= rt;
    req_ch.byte_count <= cnt;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // zero-count requests give no result, so allow extra time before touching config
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic apply_config(input logic [63:0] kh, input logic [63:0] kl,
                              input logic [63:0] ih, input logic [63:0] il,
                              input logic [63:0] len);
    write_reg(CFG_KEY_UPPER, kh);
    write_reg(CFG_KEY_LOWER, kl);
    write_reg(CFG_IV_UPPER, ih);
    write_reg(CFG_IV_LOWER, il);
    write_reg(CFG_IV_LENGTH, len);
    // unused indexes must leave the key and IV alone
    if ($urandom_range(1))
      write_reg(CFG_IV_LENGTH + CFG_INDEX_W'($urandom_range(1, 3)), {$urandom, $urandom});
    cfg_we <= 1'b0;
    n_configs++;
  endtask

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_config();
    logic [63:0] len;
    len = pick_word();
    case ($urandom_range(0, 5))
      0: len[3:0] = 4'd0;
      1: len[3:0] = 4'd10;
      default: len[3:0] = 4'($urandom_range(0, 15));
    endcase
    apply_config(pick_word(), pick_word(), pick_word(), pick_word(), len);
  endtask

  task automatic run_random(input int n_items, input int max_gap);
    int left, burst, gap, sel;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && left > 0) begin
        sel = $urandom_range(99);
        if (sel < 10)
          send_request(REQ_SETUP, BYTE_COUNT_W'($urandom));
        else if (sel < 13)
          send_request(REQ_GENERATE, '0);
        else if (sel < 16)
          send_request(REQ_GENERATE, BYTE_COUNT_W'($urandom_range(BURST_CAP + 1, 127)));
        else if (sel < 24)
          send_request(REQ_GENERATE, BYTE_COUNT_W'($urandom_range(9, BURST_CAP)));
        else
          send_request(REQ_GENERATE, BYTE_COUNT_W'($urandom_range(1, 8)));
        burst--;
        left--;
      end
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if ($urandom_range(99) < 4) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
        drain_results();
      end else if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_ch.valid <= 1'b0;
  endtask

  initial begin
    int ph, errors;
    sb = new();
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_SETUP;
    req_ch.byte_count <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    stall_pct = 30;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // keystream straight out of reset, before any setup
    send_request(REQ_GENERATE, 7'd3);
    send_request(REQ_GENERATE, 7'd0);
    req_ch.valid <= 1'b0;
    settle();

    apply_config('0, '0, '0, '0, '0);
    send_request(REQ_SETUP, 7'd0);
    send_request(REQ_GENERATE, 7'd1);
    req_ch.valid <= 1'b0;
    settle();

    // all-ones key and a full ten-byte IV, then burst limits
    apply_config('1, '1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFA);
    send_request(REQ_SETUP, 7'h7F);
    send_request(REQ_GENERATE, 7'd64);
    send_request(REQ_GENERATE, 7'd127);
    send_request(REQ_GENERATE, 7'd65);
    req_ch.valid <= 1'b0;
    settle();

    // IV length above ten is clamped
    apply_config(pick_word(), pick_word(), pick_word(), pick_word(), 64'h0F);
    send_request(REQ_SETUP, 7'd5);
    send_request(REQ_GENERATE, 7'd2);
    send_request(REQ_SETUP, 7'd0);
    send_request(REQ_SETUP, 7'h40);
    send_request(REQ_GENERATE, 7'd1);
    send_request(REQ_GENERATE, 7'd9);
    req_ch.valid <= 1'b0;
    settle();

    apply_config(pick_word(), pick_word(), pick_word(), pick_word(), 64'h1);
    send_request(REQ_SETUP, 7'd0);
    send_request(REQ_GENERATE, 7'd5);
    send_request(REQ_GENERATE, 7'd0);
    req_ch.valid <= 1'b0;

    // run_random leaves valid low when it returns
    for (ph = 0; ph < 6; ph++) begin
      settle();
      stall_pct = stall_plan[ph];
      random_config();
      send_request(REQ_SETUP, BYTE_COUNT_W'($urandom));
      run_random(59, gap_plan[ph]);
    end

    settle();
    errors = sb.n_bad + sb.n_unexpected + sb.pending();
    if (sb.pending() != 0)
      $display("%0d expected results never arrived", sb.pending());
    $display("ran %0d setups and %0d keystream requests over %0d key/IV settings",
             sb.n_setup, sb.n_generate, n_configs);
    $display("checked %0d result items, %0d mismatched, %0d unexpected",
             sb.n_checked, sb.n_bad, sb.n_unexpected);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
